@@ src/ubxpl_pkg.sv @@
// shared types and constants for the ubx position frame checker
package ubxpl_pkg;

   localparam int unsigned IDX_W       = 6;
   localparam int unsigned INDEX_MAX   = 63;
   localparam int unsigned FIELD_FIRST = 2;
   localparam int unsigned FIELD_BYTES = 32;
   localparam int unsigned WORD_COUNT  = FIELD_BYTES / 4;
   localparam int unsigned SUM_START   = 4;
   localparam int unsigned CHECK_MIN   = 3;

   typedef logic [IDX_W-1:0] index_type;
   typedef logic [7:0]       byte_type;
   typedef logic [31:0]      word_type;

   // control shared between the frame tracker and the field store
   typedef struct packed {
      logic      step;
      logic      start;
      index_type index;
   } ctl_type;

   // one decoded frame as it leaves the block
   typedef struct packed {
      logic [7:0]         msg_class;
      logic [7:0]         msg_id;
      logic [15:0]        payload_length;
      logic [31:0]        time_of_week;
      logic signed [31:0] longitude;
      logic signed [31:0] latitude;
      logic signed [31:0] height_ellipsoid;
      logic signed [31:0] height_sea_level;
      logic [31:0]        horiz_accuracy;
      logic [31:0]        vert_accuracy;
      logic               checksum_ok;
   } result_type;

endpackage

@@ src/ubxpl_if.sv @@
// valid/ready channel interfaces for frame bytes and decoded results
interface ubxpl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;

   modport source (output valid, output frame_byte, output frame_last, input ready);
   modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface ubxpl_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         msg_class;
   logic [7:0]         msg_id;
   logic [15:0]        payload_length;
   logic [31:0]        time_of_week;
   logic signed [31:0] longitude;
   logic signed [31:0] latitude;
   logic signed [31:0] height_ellipsoid;
   logic signed [31:0] height_sea_level;
   logic [31:0]        horiz_accuracy;
   logic [31:0]        vert_accuracy;
   logic               checksum_ok;

   modport source (output valid, output msg_class, output msg_id, output payload_length,
                   output time_of_week, output longitude, output latitude,
                   output height_ellipsoid, output height_sea_level,
                   output horiz_accuracy, output vert_accuracy, output checksum_ok,
                   input ready);
   modport sink   (input valid, input msg_class, input msg_id, input payload_length,
                   input time_of_week, input longitude, input latitude,
                   input height_ellipsoid, input height_sea_level,
                   input horiz_accuracy, input vert_accuracy, input checksum_ok,
                   output ready);
endinterface

@@ src/ubxpl_frame_state.sv @@
// byte index, running fletcher sums, held bytes and checksum compare
module ubxpl_frame_state (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  ubxpl_pkg::byte_type frame_byte,
   input  logic               frame_last,
   output ubxpl_pkg::ctl_type ctl,
   output logic               checksum_ok
);
   import ubxpl_pkg::*;

   index_type index_ff, index_in;
   byte_type  sum_a_ff, sum_a_in;
   byte_type  sum_b_ff, sum_b_in;
   byte_type  held_older_ff, held_newer_ff;
   logic      start;
   logic      add_en;
   byte_type  sum_a_base, sum_b_base;

   // sums restart at frame start, then take the byte two positions back
   always_comb begin
      start      = (index_ff == '0);
      add_en     = (index_ff >= IDX_W'(SUM_START));
      sum_a_base = start ? '0 : sum_a_ff;
      sum_b_base = start ? '0 : sum_b_ff;
      sum_a_in   = add_en ? byte_type'(sum_a_base + held_older_ff) : sum_a_base;
      sum_b_in   = add_en ? byte_type'(sum_b_base + sum_a_in) : sum_b_base;
   end

   // checksum compare against the two newest bytes
   assign checksum_ok = (index_ff >= IDX_W'(CHECK_MIN)) && (sum_a_in == held_newer_ff)
                        && (sum_b_in == frame_byte);

   // next index: back to zero after the last byte, otherwise count and saturate
   always_comb begin
      if (frame_last) begin
         index_in = '0;
      end else if (index_ff == IDX_W'(INDEX_MAX)) begin
         index_in = index_ff;
      end else begin
         index_in = index_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
      end else if (step) begin
         index_ff <= index_in;
      end
   end

   // sums and held bytes
   always_ff @(posedge clock) begin
      if (step) begin
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         held_older_ff <= held_newer_ff;
         held_newer_ff <= frame_byte;
      end
   end

   assign ctl.step  = step;
   assign ctl.start = start;
   assign ctl.index = index_ff;

endmodule

@@ src/ubxpl_field_store.sv @@
// gathers header and position bytes at fixed frame offsets
module ubxpl_field_store (
   input  logic                                        clock,
   input  ubxpl_pkg::ctl_type                          ctl,
   input  ubxpl_pkg::byte_type                         frame_byte,
   output logic [ubxpl_pkg::WORD_COUNT-1:0][31:0]      field_words
);
   import ubxpl_pkg::*;

   byte_type field_ff [FIELD_BYTES];
   byte_type field_in [FIELD_BYTES];

   // each byte slot clears at frame start and loads when its offset comes by
   always_comb begin
      for (int i = 0; i < FIELD_BYTES; i++) begin
         field_in[i] = ctl.start ? '0 : field_ff[i];
         if (ctl.index == IDX_W'(FIELD_FIRST + i)) begin
            field_in[i] = frame_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         for (int i = 0; i < FIELD_BYTES; i++) begin
            field_ff[i] <= field_in[i];
         end
      end
   end

   // little-endian words including the byte of this transaction
   always_comb begin
      for (int w = 0; w < WORD_COUNT; w++) begin
         field_words[w] = {field_in[4*w+3], field_in[4*w+2], field_in[4*w+1], field_in[4*w]};
      end
   end

endmodule

@@ src/ubxpl_frame_check_decode_top.sv @@
// top level of the ubx position frame checker and field decoder
//
//  channel   dir  handshake      payload
//  req_chan  in   valid/ready    frame_byte[8], frame_last[1]
//  rsp_chan  out  valid/ready    decoded position fields, checksum_ok
//
// one byte is taken every cycle while no result waits on the receiver; a frame
// result passes the input register, then the result register, once its last byte is accepted.
// reset clears the byte index and both valid flags; field bytes and sums are
// cleared at the start of every frame instead.
// a result waiting on the receiver stops the whole byte path; at most one more
// byte is taken into the input register before ready drops.
module ubx_posllh_frame_check_decode_top (
   input logic        clock,
   input logic        reset,
   ubxpl_req_if.sink   req_chan,
   ubxpl_rsp_if.source rsp_chan
);
   import ubxpl_pkg::*;

   logic       req_valid_ff;
   byte_type   req_byte_ff;
   logic       req_last_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff, rsp_in;
   logic       advance;
   logic       step;
   ctl_type    state_ctl;
   logic       checksum_ok;
   logic [WORD_COUNT-1:0][31:0] field_words;

   // pipeline moves whenever the result slot is free or being drained
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !req_valid_ff || advance;
   assign step           = req_valid_ff && advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_byte_ff <= req_chan.frame_byte;
         req_last_ff <= req_chan.frame_last;
      end
   end

   ubxpl_frame_state u_state (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .frame_byte  (req_byte_ff),
      .frame_last  (req_last_ff),
      .ctl         (state_ctl),
      .checksum_ok (checksum_ok)
   );

   ubxpl_field_store u_fields (
      .clock       (clock),
      .ctl         (state_ctl),
      .frame_byte  (req_byte_ff),
      .field_words (field_words)
   );

   // assemble the frame result
   always_comb begin
      rsp_in.msg_class        = field_words[0][7:0];
      rsp_in.msg_id           = field_words[0][15:8];
      rsp_in.payload_length   = field_words[0][31:16];
      rsp_in.time_of_week     = field_words[1];
      rsp_in.longitude        = field_words[2];
      rsp_in.latitude         = field_words[3];
      rsp_in.height_ellipsoid = field_words[4];
      rsp_in.height_sea_level = field_words[5];
      rsp_in.horiz_accuracy   = field_words[6];
      rsp_in.vert_accuracy    = field_words[7];
      rsp_in.checksum_ok      = checksum_ok;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= step && req_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step && req_last_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.msg_class        = rsp_ff.msg_class;
   assign rsp_chan.msg_id           = rsp_ff.msg_id;
   assign rsp_chan.payload_length   = rsp_ff.payload_length;
   assign rsp_chan.time_of_week     = rsp_ff.time_of_week;
   assign rsp_chan.longitude        = rsp_ff.longitude;
   assign rsp_chan.latitude         = rsp_ff.latitude;
   assign rsp_chan.height_ellipsoid = rsp_ff.height_ellipsoid;
   assign rsp_chan.height_sea_level = rsp_ff.height_sea_level;
   assign rsp_chan.horiz_accuracy   = rsp_ff.horiz_accuracy;
   assign rsp_chan.vert_accuracy    = rsp_ff.vert_accuracy;
   assign rsp_chan.checksum_ok      = rsp_ff.checksum_ok;

`ifndef SYNTHESIS
   // a new result only follows a processed last byte
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step && req_last_ff))
      else $error("result valid without a last byte");

   // the byte index restarts after every frame end
   a_index_restart: assert property (@(posedge clock) disable iff (reset)
      (step && req_last_ff) |=> (state_ctl.index == '0))
      else $error("byte index not cleared after frame end");

   // mid-frame bytes advance the index by one until it saturates
   a_index_count: assert property (@(posedge clock) disable iff (reset)
      (step && !req_last_ff && (state_ctl.index != IDX_W'(INDEX_MAX)))
      |=> (state_ctl.index == IDX_W'($past(state_ctl.index) + IDX_W'(1))))
      else $error("byte index did not advance");

   // a held input byte is not lost while the result slot is blocked
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> (req_valid_ff && $stable(req_byte_ff)))
      else $error("input byte changed while stalled");
`endif

endmodule
